### sv/bls_pkg.sv
// Shared constants for the Bresenham line stepper.
// Used by every module of the block; no dependencies of its own.
package bls_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 4;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'd1;

    // command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_PIXEL_COLOR = 1'b0;  // paddr[2] of the colour register

endpackage

### sv/bls_apb_regs.sv
// APB register file of the line stepper: holds the pixel colour register.
// Depends on bls_pkg.
module bls_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [bls_pkg::APB_ADDR_BITS-1:0] i_paddr,
    input  logic [bls_pkg::APB_DATA_BITS-1:0] i_pwdata,
    output logic [bls_pkg::APB_DATA_BITS-1:0] o_prdata,
    output logic                              o_pready,
    output logic [bls_pkg::COLOR_BITS-1:0]    o_color
);
    import bls_pkg::*;

    logic [COLOR_BITS-1:0] r_color_q;
    logic [COLOR_BITS-1:0] n_color;
    logic                  wr_en;
    logic                  sel_color;

    // low address bits are the byte lane and are not decoded
    assign sel_color = (i_paddr[2] == REG_PIXEL_COLOR);
    assign wr_en     = i_psel && i_penable && i_pwrite && sel_color;
    assign n_color   = wr_en ? i_pwdata[COLOR_BITS-1:0] : r_color_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_q <= COLOR_RESET;
        end else begin
            r_color_q <= n_color;
        end
    end

    assign o_color  = r_color_q;
    assign o_pready = 1'b1;
    assign o_prdata = sel_color ? APB_DATA_BITS'(r_color_q) : '0;

endmodule

### sv/bls_stepper.sv
// Line state and one-step datapath of the Bresenham stepper: loads endpoints
// on a start word, emits one pixel per step word. Depends on bls_pkg.
module bls_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic                           i_cmd,
    input  logic [COORD_BITS-1:0]          i_x_start,
    input  logic [COORD_BITS-1:0]          i_y_start,
    input  logic [COORD_BITS-1:0]          i_x_end,
    input  logic [COORD_BITS-1:0]          i_y_end,
    input  logic [bls_pkg::COLOR_BITS-1:0] i_color,
    output logic                           o_res_valid,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic [bls_pkg::COLOR_BITS-1:0] o_pixel_colour,
    output logic                           o_last_pixel
);
    import bls_pkg::*;

    localparam int EW = COORD_BITS + 2;

    logic [COORD_BITS-1:0]   r_cur_x, r_cur_y;
    logic signed [EW-1:0]    r_err;
    logic [COORD_BITS-1:0]   r_major, r_minor, r_done;
    logic [1:0]              r_dir_x, r_dir_y;
    logic                    r_steep, r_active;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      adx, ady, st_major, st_minor;
    logic [1:0]                 st_dir_x, st_dir_y;
    logic                       st_steep;
    logic signed [EW-1:0]       st_err;

    logic                       last, minor_go, move_x, move_y;
    logic [COORD_BITS-1:0]      step_x, step_y;
    logic [COORD_BITS-1:0]      n_cur_x, n_cur_y;
    logic signed [EW:0]         err_sum;

    // start: deltas, octant and initial error
    always_comb begin
        dx       = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
        dy       = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
        adx      = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady      = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        st_dir_x = dx[COORD_BITS] ? 2'b11 : ((dx != '0) ? 2'b01 : 2'b00);
        st_dir_y = dy[COORD_BITS] ? 2'b11 : ((dy != '0) ? 2'b01 : 2'b00);
        st_steep = (ady > adx);
        st_major = st_steep ? ady : adx;
        st_minor = st_steep ? adx : ady;
        st_err   = $signed(EW'({st_minor, 1'b0}) - EW'(st_major));
    end

    // step: major axis always moves, minor axis when the error is non-negative
    always_comb begin
        last     = (r_done >= r_major);
        minor_go = !r_err[EW-1];
        move_x   = r_steep ? minor_go : 1'b1;
        move_y   = r_steep ? 1'b1 : minor_go;
        step_x   = {{(COORD_BITS-2){r_dir_x[1]}}, r_dir_x};
        step_y   = {{(COORD_BITS-2){r_dir_y[1]}}, r_dir_y};
        n_cur_x  = move_x ? (r_cur_x + step_x) : r_cur_x;
        n_cur_y  = move_y ? (r_cur_y + step_y) : r_cur_y;
        err_sum  = $signed({r_err[EW-1], r_err}) + $signed({2'b00, r_minor, 1'b0})
                 - (minor_go ? $signed({2'b00, r_major, 1'b0}) : $signed((EW+1)'(0)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_err    <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_dir_x  <= '0;
            r_dir_y  <= '0;
            r_steep  <= 1'b0;
            r_done   <= '0;
            r_active <= 1'b0;
        end else if (i_go) begin
            if (i_cmd == CMD_START) begin
                r_cur_x  <= i_x_start;
                r_cur_y  <= i_y_start;
                r_err    <= st_err;
                r_major  <= st_major;
                r_minor  <= st_minor;
                r_dir_x  <= st_dir_x;
                r_dir_y  <= st_dir_y;
                r_steep  <= st_steep;
                r_done   <= '0;
                r_active <= 1'b1;
            end else if (r_active) begin
                if (last) begin
                    r_active <= 1'b0;
                end else begin
                    r_cur_x <= n_cur_x;
                    r_cur_y <= n_cur_y;
                    r_err   <= err_sum[EW-1:0];
                    r_done  <= r_done + COORD_BITS'(1);
                end
            end
        end
    end

    assign o_res_valid    = i_go && (i_cmd == CMD_STEP) && r_active;
    assign o_pixel_x      = r_cur_x;
    assign o_pixel_y      = r_cur_y;
    assign o_pixel_colour = i_color;
    assign o_last_pixel   = last;

endmodule

### sv/bresenham_line_stepper_core.sv
// Top level of the Bresenham line stepper: input word register, stepper,
// output word register and APB configuration. Depends on bls_pkg,
// bls_stepper and bls_apb_regs.
//
// Use: a slave stream carries command words. tuser = 0 is a start word whose
// tdata holds both endpoints; it loads the line and produces no output word.
// tuser = 1 is a step word; it produces the next pixel of the active line on
// the master stream (tlast on the final endpoint), or nothing if no line is
// active. A start word during a line drops the old line.
// Colour comes from the APB register at address 0 (reset value 1) and is
// attached to each pixel as it is produced; write it only while idle.
// A word accepted on the slave side passes the input register, then the output
// register, before its pixel shows. Throughput: one word per cycle while the master
// side takes words; bls_stepper computes the error/coordinate update combinationally.
// When the master side stalls, the output register holds its word and the
// input register takes one more word, after which s_axis_tready drops.
// Reset (synchronous, active low) empties both registers, clears the line
// state and sets the colour to 1.
module bresenham_line_stepper_core #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                              s_axis_tuser,   // cmd
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_x, pixel_y, pixel_colour from bit 0 up, zero padded
    output logic [((2*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                              m_axis_tlast,   // last_pixel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bls_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bls_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bls_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import bls_pkg::*;

    localparam int OUT_DATA_W = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

    logic                  r_in_valid;
    logic                  r_in_cmd;
    logic [COORD_BITS-1:0] r_xs, r_ys, r_xe, r_ye;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [COLOR_BITS-1:0] r_pc;
    logic                  r_plast;

    logic                  in_take, out_free, stage_go;
    logic [COLOR_BITS-1:0] color;
    logic                  res_valid;
    logic [COORD_BITS-1:0] res_x, res_y;
    logic [COLOR_BITS-1:0] res_c;
    logic                  res_last;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign stage_go      = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (stage_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd <= s_axis_tuser;
            r_xs     <= s_axis_tdata[COORD_BITS-1:0];
            r_ys     <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_xe     <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            r_ye     <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
    end

    bls_stepper #(
        .COORD_BITS(COORD_BITS)
    ) u_stepper (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (stage_go),
        .i_cmd          (r_in_cmd),
        .i_x_start      (r_xs),
        .i_y_start      (r_ys),
        .i_x_end        (r_xe),
        .i_y_end        (r_ye),
        .i_color        (color),
        .o_res_valid    (res_valid),
        .o_pixel_x      (res_x),
        .o_pixel_y      (res_y),
        .o_pixel_colour (res_c),
        .o_last_pixel   (res_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_px    <= res_x;
            r_py    <= res_y;
            r_pc    <= res_c;
            r_plast <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_pc, r_py, r_px});
    assign m_axis_tlast  = r_plast;

    bls_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_color   (color)
    );

endmodule
